// ===== rtl/pvl_pkg.sv =====
package pvl_pkg;

   // defaults for the top-level parameters
   localparam int DEF_WORD_DEPTH     = 4096;
   localparam int DEF_MAX_ENTRY_BITS = 16;

   // field widths
   localparam int SIZE_W  = 11;
   localparam int COORD_W = 10;
   localparam int EBITS_W = 5;
   localparam int WCNT_W  = 13;
   localparam int WIDX_W  = 12;
   localparam int WORD_W  = 64;
   localparam int ID_W    = 16;
   localparam int STAT_W  = 2;

   // stream packing
   localparam int REQ_FIELDS_W = WIDX_W + WORD_W + 3 * COORD_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = ID_W + STAT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // address arithmetic
   localparam int PROD1_W  = COORD_W + SIZE_W;       // y*size_x, z*size_x
   localparam int SUM1_W   = PROD1_W + 1;            // z*size_x + x
   localparam int LIN_W    = PROD1_W + SIZE_W;       // y*size_x*size_z
   localparam int BITPOS_W = LIN_W + EBITS_W;
   localparam int SHIFT_W  = 6;
   localparam int FIRST_W  = BITPOS_W - SHIFT_W;
   localparam int CMP_W    = 32;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = WCNT_W;

   localparam logic [CSR_ADDR_W-1:0] CSR_SIZE_X     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SIZE_Y     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SIZE_Z     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ENTRY_BITS = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_WORD_COUNT = 3'd4;

   localparam logic [EBITS_W-1:0] ENTRY_BITS_RESET = 5'd2;
   localparam logic [EBITS_W-1:0] ENTRY_BITS_MIN   = 5'd2;

   // item kinds on tuser
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_COORD = 2'd1,
      ST_WORDS = 2'd2
   } status_type;

   typedef struct packed {
      logic [SIZE_W-1:0]  size_x;
      logic [SIZE_W-1:0]  size_y;
      logic [SIZE_W-1:0]  size_z;
      logic [EBITS_W-1:0] entry_bits;
      logic [WCNT_W-1:0]  word_count;
   } cfg_type;

   typedef struct packed {
      logic                is_query;
      logic                coord_err;
      logic [WIDX_W-1:0]   word_index;
      logic [WORD_W-1:0]   word_value;
      logic [BITPOS_W-1:0] bitpos;
      logic [EBITS_W-1:0]  bits;
   } addr_type;

endpackage

// ===== rtl/pvl_addr.sv =====
module pvl_addr #(
   parameter int MAX_ENTRY_BITS = pvl_pkg::DEF_MAX_ENTRY_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pvl_pkg::cfg_type              cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          in_func,
   input  logic [pvl_pkg::WIDX_W-1:0]    in_word_index,
   input  logic [pvl_pkg::WORD_W-1:0]    in_word_value,
   input  logic [pvl_pkg::COORD_W-1:0]   in_x,
   input  logic [pvl_pkg::COORD_W-1:0]   in_y,
   input  logic [pvl_pkg::COORD_W-1:0]   in_z,
   output logic                          out_valid,
   input  logic                          out_ready,
   output pvl_pkg::addr_type             out_addr
);
   import pvl_pkg::*;

   localparam logic [EBITS_W-1:0] MAX_BITS = EBITS_W'(MAX_ENTRY_BITS);

   // stage 1: range check, first products
   logic                v1_ff, v1_in;
   logic                isq1_ff;
   logic                err1_ff, err1_in;
   logic [WIDX_W-1:0]   widx1_ff;
   logic [WORD_W-1:0]   wval1_ff;
   logic [COORD_W-1:0]  x1_ff;
   logic [PROD1_W-1:0]  yx1_ff, yx1_in;
   logic [PROD1_W-1:0]  zx1_ff, zx1_in;

   // stage 2: linear index parts
   logic                v2_ff, v2_in;
   logic                isq2_ff;
   logic                err2_ff;
   logic [WIDX_W-1:0]   widx2_ff;
   logic [WORD_W-1:0]   wval2_ff;
   logic [LIN_W-1:0]    p2_ff, p2_in;
   logic [SUM1_W-1:0]   q2_ff, q2_in;

   // stage 3: bit position
   logic                v3_ff, v3_in;
   addr_type            a3_ff, a3_in;

   logic                adv1, adv2, adv3;
   logic [LIN_W-1:0]    lin;
   logic [EBITS_W-1:0]  bits_eff;

   assign adv3     = !v3_ff || out_ready;
   assign adv2     = !v2_ff || adv3;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   assign v1_in = adv1 ? in_valid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;

   assign err1_in = ({1'b0, in_x} >= cfg.size_x) || ({1'b0, in_y} >= cfg.size_y) ||
                    ({1'b0, in_z} >= cfg.size_z);
   assign yx1_in  = PROD1_W'(in_y) * PROD1_W'(cfg.size_x);
   assign zx1_in  = PROD1_W'(in_z) * PROD1_W'(cfg.size_x);

   assign p2_in = LIN_W'(yx1_ff) * LIN_W'(cfg.size_z);
   assign q2_in = SUM1_W'(zx1_ff) + SUM1_W'(x1_ff);

   always_comb begin
      bits_eff = cfg.entry_bits;
      if (cfg.entry_bits < ENTRY_BITS_MIN) begin
         bits_eff = ENTRY_BITS_MIN;
      end else if (cfg.entry_bits > MAX_BITS) begin
         bits_eff = MAX_BITS;
      end
   end

   assign lin = p2_ff + LIN_W'(q2_ff);

   always_comb begin
      a3_in            = '0;
      a3_in.is_query   = isq2_ff;
      a3_in.coord_err  = err2_ff;
      a3_in.word_index = widx2_ff;
      a3_in.word_value = wval2_ff;
      a3_in.bitpos     = BITPOS_W'(lin) * BITPOS_W'(bits_eff);
      a3_in.bits       = bits_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         isq1_ff  <= (in_func == FUNC_QUERY);
         err1_ff  <= err1_in;
         widx1_ff <= in_word_index;
         wval1_ff <= in_word_value;
         x1_ff    <= in_x;
         yx1_ff   <= yx1_in;
         zx1_ff   <= zx1_in;
      end
      if (adv2) begin
         isq2_ff  <= isq1_ff;
         err2_ff  <= err1_ff;
         widx2_ff <= widx1_ff;
         wval2_ff <= wval1_ff;
         p2_ff    <= p2_in;
         q2_ff    <= q2_in;
      end
      if (adv3) begin
         a3_ff <= a3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_addr  = a3_ff;

`ifndef SYNTH
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> (v1_ff && v2_ff && v3_ff && !out_ready))
      else $error("input stalled while the pipeline has a free slot");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> (out_valid && $stable(out_addr)))
      else $error("address stage changed while stalled");

   a_bits_clamped: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_addr.bits >= ENTRY_BITS_MIN && out_addr.bits <= MAX_BITS))
      else $error("entry width outside its clamp range");
`endif

endmodule

// ===== rtl/packed_voxel_id_lookup.sv =====
// Five register stages: three address stages, one store read, one extract/output.
// Throughput: one word per cycle while rsp_tready is high; the multipliers are
//   pipelined, the store takes one write and two reads per cycle, and each
//   stage stalls only when full.
// Reset (synchronous, active high) clears all valid flags and loads the config
//   registers with their defaults; store contents are undefined until written.
module packed_voxel_id_lookup #(
   parameter int WORD_DEPTH     = pvl_pkg::DEF_WORD_DEPTH,
   parameter int MAX_ENTRY_BITS = pvl_pkg::DEF_MAX_ENTRY_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration write port
   input  logic                              csr_we,
   input  logic [pvl_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [pvl_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // req_tdata from bit 0: word_index[11:0], word_value[63:0], x[9:0], y[9:0],
   // z[9:0], zero fill
   input  logic [pvl_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_tuser: func (0 store write, 1 lookup)
   input  logic                              req_tuser,
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rsp_tdata from bit 0: entry_id[15:0], status[1:0], zero fill
   output logic [pvl_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import pvl_pkg::*;

   localparam int ADDR_W = $clog2(WORD_DEPTH);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_SIZE_X:     cfg_in.size_x     = csr_wdata[SIZE_W-1:0];
            CSR_SIZE_Y:     cfg_in.size_y     = csr_wdata[SIZE_W-1:0];
            CSR_SIZE_Z:     cfg_in.size_z     = csr_wdata[SIZE_W-1:0];
            CSR_ENTRY_BITS: cfg_in.entry_bits = csr_wdata[EBITS_W-1:0];
            CSR_WORD_COUNT: cfg_in.word_count = csr_wdata[WCNT_W-1:0];
            default:        cfg_in = cfg_ff;   // unmapped index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // fields from the top: size_x, size_y, size_z, entry_bits, word_count
         cfg_ff <= {SIZE_W'(0), SIZE_W'(0), SIZE_W'(0), ENTRY_BITS_RESET, WCNT_W'(0)};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------------
   // Unpack the request word
   // ---------------------------------------------------------------------
   logic [WIDX_W-1:0]  req_word_index;
   logic [WORD_W-1:0]  req_word_value;
   logic [COORD_W-1:0] req_x, req_y, req_z;

   assign req_word_index = req_tdata[WIDX_W-1:0];
   assign req_word_value = req_tdata[WIDX_W+WORD_W-1:WIDX_W];
   assign req_x = req_tdata[WIDX_W+WORD_W+COORD_W-1:WIDX_W+WORD_W];
   assign req_y = req_tdata[WIDX_W+WORD_W+2*COORD_W-1:WIDX_W+WORD_W+COORD_W];
   assign req_z = req_tdata[WIDX_W+WORD_W+3*COORD_W-1:WIDX_W+WORD_W+2*COORD_W];

   // ---------------------------------------------------------------------
   // Stages 1-3: range check and bit position y*sx*sz + z*sx + x, times width
   // ---------------------------------------------------------------------
   logic     addr_valid, addr_ready;
   addr_type addr;

   pvl_addr #(
      .MAX_ENTRY_BITS (MAX_ENTRY_BITS)
   ) u_addr (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_func       (req_tuser),
      .in_word_index (req_word_index),
      .in_word_value (req_word_value),
      .in_x          (req_x),
      .in_y          (req_y),
      .in_z          (req_z),
      .out_valid     (addr_valid),
      .out_ready     (addr_ready),
      .out_addr      (addr)
   );

   // ---------------------------------------------------------------------
   // Stage 4: word-limit check, store write, two-word store read
   // ---------------------------------------------------------------------
   logic               v4_ff, v4_in;
   logic               v5_ff, v5_in;
   logic               adv4, adv5;

   logic [FIRST_W-1:0] first;
   logic [SHIFT_W-1:0] shift;
   logic [CMP_W-1:0]   first_ext;
   logic [CMP_W-1:0]   limit;
   logic               straddle;
   logic               word_err;
   status_type         stat4_in;

   logic [ADDR_W-1:0]  rd_addr0, rd_addr1, wr_addr;
   logic               wr_en;

   logic [WORD_W-1:0]  mem [WORD_DEPTH];
   logic [WORD_W-1:0]  rd0_ff, rd1_ff;
   logic               isq4_ff;
   logic [SHIFT_W-1:0] shift4_ff;
   logic [EBITS_W-1:0] bits4_ff;
   status_type         stat4_ff;

   // advance a stage when it is empty or its successor moves
   assign adv5       = !v5_ff || rsp_tready;
   assign adv4       = !v4_ff || adv5;
   assign addr_ready = adv4;

   assign v4_in = adv4 ? addr_valid : v4_ff;
   assign v5_in = adv5 ? v4_ff : v5_ff;

   assign first     = addr.bitpos[BITPOS_W-1:SHIFT_W];
   assign shift     = addr.bitpos[SHIFT_W-1:0];
   assign first_ext = CMP_W'(first);

   // usable words: the smaller of the programmed count and the store depth
   assign limit = (CMP_W'(cfg_ff.word_count) < CMP_W'(WORD_DEPTH)) ?
                  CMP_W'(cfg_ff.word_count) : CMP_W'(WORD_DEPTH);

   // an entry straddles when it runs past bit 63 of its first word
   assign straddle = (7'(shift) + 7'(addr.bits)) > 7'(WORD_W);
   assign word_err = (first_ext >= limit) ||
                     (straddle && ((first_ext + CMP_W'(1)) >= limit));

   always_comb begin
      if (!addr.is_query) begin
         stat4_in = ST_OK;
      end else if (addr.coord_err) begin
         stat4_in = ST_COORD;
      end else if (word_err) begin
         stat4_in = ST_WORDS;
      end else begin
         stat4_in = ST_OK;
      end
   end

   assign rd_addr0 = first[ADDR_W-1:0];
   assign rd_addr1 = rd_addr0 + ADDR_W'(1);   // wraps only when unused or flagged
   assign wr_addr  = ADDR_W'(addr.word_index);
   // drop writes past the store depth
   assign wr_en    = adv4 && addr_valid && !addr.is_query &&
                     (CMP_W'(addr.word_index) < CMP_W'(WORD_DEPTH));

   // write and read in the same step keeps store order equal to stream order
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= addr.word_value;
      end
      if (adv4) begin
         rd0_ff <= mem[rd_addr0];
         rd1_ff <= mem[rd_addr1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         isq4_ff   <= addr.is_query;
         shift4_ff <= shift;
         bits4_ff  <= addr.bits;
         stat4_ff  <= stat4_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: funnel shift, mask, output register
   // ---------------------------------------------------------------------
   logic [2*WORD_W-1:0] funnel;
   logic [CMP_W-1:0]    mask;
   logic [ID_W-1:0]     id5_ff, id5_in;
   status_type          stat5_ff;

   assign funnel = {rd1_ff, rd0_ff} >> shift4_ff;
   assign mask   = (CMP_W'(1) << bits4_ff) - CMP_W'(1);
   // zero the id on writes and on any error
   assign id5_in = (isq4_ff && stat4_ff == ST_OK) ?
                   (funnel[ID_W-1:0] & mask[ID_W-1:0]) : '0;

   always_ff @(posedge clock) begin
      if (adv5) begin
         id5_ff   <= id5_in;
         stat5_ff <= stat4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_FIELDS_W)'(0), stat5_ff, id5_ff};

`ifndef SYNTH
   a_err_zero_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && stat5_ff != ST_OK) |-> (id5_ff == '0))
      else $error("entry id not zero on an error response");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !v4_ff))
      else $error("pipeline holds data after reset");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (!addr_ready) |-> (v4_ff && rsp_tvalid && !rsp_tready))
      else $error("read stage stalled with a free slot downstream");

   a_no_write_on_query: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (addr_valid && !addr.is_query && adv4))
      else $error("store written outside a write word");
`endif

endmodule

// ===== tb/packed_voxel_id_lookup_test.sv =====
`timescale 1ns / 100ps

module packed_voxel_id_lookup_test;
   import pvl_pkg::*;

   localparam int STORE_DEPTH    = DEF_WORD_DEPTH;
   localparam int ID_BITS_MAX    = DEF_MAX_ENTRY_BITS;
   localparam int QUIET_LIMIT    = 1000;  // cycles with no handshake before giving up
   localparam int TAIL_CYCLES    = 20;    // settle time after the last rsp word
   localparam int REPORT_LIMIT   = 10;

   // one req word as the stimulus sees it; steady words suppress idling on both sides
   typedef struct {
      logic               func;
      logic [WIDX_W-1:0]  word_index;
      logic [WORD_W-1:0]  word_value;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      bit                 steady;
   } lookup_word_type;

   typedef struct {
      logic [ID_W-1:0] entry_id;
      status_type      status;
   } id_answer_type;

   // DUT connections; all inputs driven to known values from time zero
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // predictor state: register image and store image
   cfg_type           region;
   logic [WORD_W-1:0] word_image [0:STORE_DEPTH-1];

   // stimulus bookkeeping: which store words have a load queued so far
   bit                written [0:STORE_DEPTH-1];
   bit                steady_gen = 1'b0;

   lookup_word_type   pending_words[$];
   id_answer_type     expected_answers[$];
   lookup_word_type   on_bus;
   bit                calm_now = 1'b0;
   int                req_gap = 0;
   int                rsp_gap = 0;
   int                mismatches = 0;
   int                quiet_cycles = 0;
   logic [ID_W-1:0]   got_id;
   logic [STAT_W-1:0] got_status;
   id_answer_type     want;

   packed_voxel_id_lookup u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Clamp the programmed width into the supported range of entry sizes.
   function automatic logic [EBITS_W-1:0] eff_width();
      if (region.entry_bits < ENTRY_BITS_MIN) return ENTRY_BITS_MIN;
      if (region.entry_bits > ID_BITS_MAX) return EBITS_W'(ID_BITS_MAX);
      return region.entry_bits;
   endfunction

   // Find where a cell's id lives. Returns the status the lookup ends with before any
   // store read; on ST_OK the id starts at bit shift of word first, and it straddles
   // into first + 1 when shift + width passes the word boundary.
   function automatic status_type locate_entry(input logic [COORD_W-1:0] qx, qy, qz,
                                               output logic [63:0] first,
                                               output logic [5:0] shift,
                                               output logic [EBITS_W-1:0] width);
      logic [63:0] lin, bitpos, limit;
      first = '0;
      shift = '0;
      width = eff_width();
      // range check comes first, so a zero extent flags every query
      if (qx >= region.size_x || qy >= region.size_y || qz >= region.size_z) return ST_COORD;
      lin    = 64'(qy) * region.size_x * region.size_z + 64'(qz) * region.size_x + 64'(qx);
      bitpos = lin * width;
      first  = bitpos >> 6;
      shift  = bitpos[5:0];
      limit  = region.word_count < STORE_DEPTH ? 64'(region.word_count) : 64'(STORE_DEPTH);
      if (first >= limit) return ST_WORDS;
      if (shift + width > 64 && first + 1 >= limit) return ST_WORDS;
      return ST_OK;
   endfunction

   // Apply one accepted req word to the store image and work out its rsp word.
   function automatic id_answer_type predict_answer(input lookup_word_type w);
      logic [63:0]        first, v;
      logic [5:0]         shift;
      logic [EBITS_W-1:0] width;
      id_answer_type      a;
      a.entry_id = '0;
      a.status   = ST_OK;
      if (w.func == FUNC_WRITE) begin
         word_image[w.word_index] = w.word_value;
      end else begin
         a.status = locate_entry(w.x, w.y, w.z, first, shift, width);
         if (a.status == ST_OK) begin
            // funnel the upper word in when the id crosses the boundary
            v = word_image[first] >> shift;
            if (shift + width > 64) v |= word_image[first + 1] << (64 - shift);
            a.entry_id = ID_W'(v & ((64'd1 << width) - 64'd1));
         end
      end
      return a;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_req(input lookup_word_type w);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[REQ_FIELDS_W-1:0] = {w.z, w.y, w.x, w.word_value, w.word_index};
      return d;
   endfunction

   // Queue a store load; the coordinate fields carry noise the block must ignore.
   function automatic void push_write(input logic [WIDX_W-1:0] idx, input logic [63:0] val);
      lookup_word_type w;
      w.func       = FUNC_WRITE;
      w.word_index = idx;
      w.word_value = val;
      w.x          = COORD_W'($urandom);
      w.y          = COORD_W'($urandom);
      w.z          = COORD_W'($urandom);
      w.steady     = steady_gen;
      written[idx] = 1'b1;
      pending_words.push_back(w);
   endfunction

   // Queue a lookup; first load any store word it would read that was never loaded.
   function automatic void push_query(input logic [COORD_W-1:0] qx, qy, qz);
      logic [63:0]        first;
      logic [5:0]         shift;
      logic [EBITS_W-1:0] width;
      lookup_word_type    w;
      if (locate_entry(qx, qy, qz, first, shift, width) == ST_OK) begin
         if (!written[first]) push_write(WIDX_W'(first), {$urandom, $urandom});
         if (shift + width > 64 && !written[first + 1])
            push_write(WIDX_W'(first + 1), {$urandom, $urandom});
      end
      w.func       = FUNC_QUERY;
      w.word_index = WIDX_W'($urandom);
      w.word_value = {$urandom, $urandom};
      w.x          = qx;
      w.y          = qy;
      w.z          = qz;
      w.steady     = steady_gen;
      pending_words.push_back(w);
   endfunction

   // Pick a coordinate at or around the region boundary.
   function automatic logic [COORD_W-1:0] border_coord(input logic [SIZE_W-1:0] extent);
      case ($urandom_range(0, 3))
         0: return '0;
         1: return extent == 0 ? '0 : COORD_W'(extent - 1);
         2: return extent > 1023 ? '1 : COORD_W'(extent);
         default: return '1;
      endcase
   endfunction

   // Random mix: half lookups that land in or just past the loaded words (if the region
   // has cells), the rest store loads, fully random coordinates and boundary coordinates.
   function automatic void push_random(input int n, input bit tail_calm);
      int unsigned  cells, span, lin, lim, pick;
      logic [COORD_W-1:0] qx, qy, qz;
      for (int k = 0; k < n; k++) begin
         steady_gen = (tail_calm && k >= n - 80) || ((k / 40) % 5 == 4);
         pick  = $urandom_range(0, 99);
         cells = 32'(region.size_x) * 32'(region.size_y) * 32'(region.size_z);
         lim   = region.word_count < STORE_DEPTH ? region.word_count : STORE_DEPTH;
         if (pick < 20) begin
            if ($urandom_range(0, 1) == 0 || lim == 0)
               push_write(WIDX_W'($urandom_range(0, STORE_DEPTH - 1)), {$urandom, $urandom});
            else
               push_write(WIDX_W'($urandom_range(0, lim - 1)), {$urandom, $urandom});
         end else if (pick < 70 && cells != 0) begin
            span = 32'(region.word_count) * 64 / eff_width() + 8;
            lin  = $urandom % (cells < span ? cells : span);
            qx   = COORD_W'(lin % region.size_x);
            qz   = COORD_W'((lin / region.size_x) % region.size_z);
            qy   = COORD_W'(lin / (32'(region.size_x) * region.size_z));
            push_query(qx, qy, qz);
         end else if (pick < 85) begin
            push_query(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
         end else begin
            push_query(border_coord(region.size_x), border_coord(region.size_y),
                       border_coord(region.size_z));
         end
      end
      steady_gen = 1'b0;
   endfunction

   // Program all five registers back to back, then drop the write enable.
   task automatic set_region(input int sx, sy, sz, eb, wc);
      @(posedge clock);
      csr_we <= 1'b1; csr_addr <= CSR_SIZE_X; csr_wdata <= CSR_DATA_W'(sx);
      region.size_x = SIZE_W'(sx);
      @(posedge clock);
      csr_addr <= CSR_SIZE_Y; csr_wdata <= CSR_DATA_W'(sy);
      region.size_y = SIZE_W'(sy);
      @(posedge clock);
      csr_addr <= CSR_SIZE_Z; csr_wdata <= CSR_DATA_W'(sz);
      region.size_z = SIZE_W'(sz);
      @(posedge clock);
      csr_addr <= CSR_ENTRY_BITS; csr_wdata <= CSR_DATA_W'(eb);
      region.entry_bits = EBITS_W'(eb);
      @(posedge clock);
      csr_addr <= CSR_WORD_COUNT; csr_wdata <= CSR_DATA_W'(wc);
      region.word_count = WCNT_W'(wc);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Hold until every queued word went out and every rsp word came back.
   task automatic wait_drained();
      while (pending_words.size() != 0 || req_tvalid || expected_answers.size() != 0)
         @(posedge clock);
   endtask

   // Stimulus: directed words first, then random phases under several register settings.
   initial begin
      region            = '0;
      region.entry_bits = ENTRY_BITS_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // zero extents: every lookup is out of range; load extreme words
      set_region(0, 0, 0, 2, 0);
      push_query('0, '0, '0);
      push_query('1, '1, '1);
      push_write('1, '1);
      push_write('0, '0);
      push_random(30, 1'b0);
      wait_drained();

      // full extents, 16-bit ids, two words: first id, last id in each word, then past the words
      set_region(1024, 1024, 1024, 16, 2);
      push_query(10'd0, 10'd0, 10'd0);
      push_query(10'd3, 10'd0, 10'd0);
      push_query(10'd7, 10'd0, 10'd0);
      push_query(10'd8, 10'd0, 10'd0);
      push_query(10'd0, 10'd1, 10'd0);
      push_query('1, '1, '1);
      push_random(60, 1'b0);
      wait_drained();

      // 13-bit ids straddle words; one straddles past the last stored word; then each axis out of range
      set_region(5, 3, 7, 13, 2);
      push_query(10'd4, 10'd0, 10'd0);
      push_query(10'd3, 10'd0, 10'd1);
      push_query(10'd4, 10'd0, 10'd1);
      push_query(10'd5, 10'd0, 10'd0);
      push_query(10'd0, 10'd3, 10'd0);
      push_query(10'd0, 10'd0, 10'd7);
      push_random(150, 1'b0);
      wait_drained();

      // widths below and above the supported range get clamped
      set_region(10, 10, 10, 0, 16);
      push_random(100, 1'b0);
      wait_drained();
      set_region(7, 9, 11, 31, 100);
      push_random(100, 1'b0);
      wait_drained();

      // word count equal to the store depth, narrow ids
      set_region(1024, 4, 1, 5, 4096);
      push_random(200, 1'b0);
      wait_drained();

      // zero word count: every in-range lookup runs past the words
      set_region(1, 1024, 1, 3, 0);
      push_random(50, 1'b0);
      wait_drained();

      // odd sizes, closing stretch without idling
      set_region(33, 17, 9, 11, 700);
      push_random(200, 1'b1);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Request driver: predict on acceptance, then advance to the next word or idle a burst.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) expected_answers.push_back(predict_answer(on_bus));
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (!pending_words[0].steady && $urandom_range(0, 5) == 0) begin
               // idle for a random gap before the next word
               req_gap = $urandom_range(0, 2);
               req_tvalid <= 1'b0;
            end else begin
               on_bus = pending_words.pop_front();
               calm_now   <= on_bus.steady;
               req_tvalid <= 1'b1;
               req_tdata  <= pack_req(on_bus);
               req_tuser  <= on_bus.func;
            end
         end
      end
   end

   // Response monitor: check each accepted word against the oldest expectation,
   // and stall tready in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_id     = rsp_tdata[ID_W-1:0];
            got_status = rsp_tdata[ID_W +: STAT_W];
            if (expected_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("rsp word with nothing expected: entry_id %h status %0d",
                           got_id, got_status);
            end else begin
               want = expected_answers.pop_front();
               if (got_id !== want.entry_id || got_status !== want.status) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("rsp mismatch: expected entry_id %h status %0d, got %h status %0d",
                              want.entry_id, want.status, got_id, got_status);
               end
            end
         end
         if (rsp_gap != 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (!calm_now && $urandom_range(0, 5) == 0) begin
            rsp_gap = $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when no word moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
